@@ hw/rtl/ious_pkg.sv @@
// Shared types and constants for the insertion-ordered unique set.
package ious_pkg;

  // Number of entries in the cell chain.
  localparam int CAPACITY = 64;
  // Bits of a stored value (at most the 32 bits of the input field).
  localparam int VAL_BITS = 32;
  // Index into the chain and occupancy count widths.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Operation codes carried by the input beat.
  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // Status codes carried by the result beat.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic cmp;    // capture the key compare result
    logic shift;  // take the upper neighbor's entry
    logic load;   // take the broadcast key as a new entry
  } cell_ctl_t;

endpackage

@@ hw/rtl/ious_cell.sv @@
// One storage cell of the chain: an entry, its valid bit and a key match flag.
module ious_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  ious_pkg::cell_ctl_t             ctl,
  input  logic [ious_pkg::VAL_BITS-1:0]   key,
  input  logic [ious_pkg::VAL_BITS-1:0]   up_value,
  input  logic                            up_valid,
  output logic [ious_pkg::VAL_BITS-1:0]   value,
  output logic                            valid,
  output logic                            match
);
  import ious_pkg::*;

  // Control state: the valid bit follows shifts and loads, match is sampled on compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.shift) begin
        valid <= up_valid;
      end else if (ctl.load) begin
        valid <= 1'b1;
      end
      if (ctl.cmp) begin
        match <= valid && (value == key);
      end
    end
  end

  // Payload: the entry moves down the chain on a shift or takes the key on a load.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= up_value;
    end else if (ctl.load) begin
      value <= key;
    end
  end

endmodule

@@ hw/rtl/insertion_ordered_unique_set_core.sv @@
// Top level of the insertion-ordered unique set: sequencer over a chain of cells.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    kind, item_value
//   out       source     out_valid/out_ready  status, front_value, is_empty, stored_count
//
// Each operation passes through four steps: accept, compare in every cell, update the
// chain, and load the result register. The compare and the update each need
// one pass over the cell chain.
// Reset clears the occupancy count and all cell valid bits at once.
// A result that is not taken holds the block in the report step; the next
// input beat is taken once the result register has been loaded.
module insertion_ordered_unique_set_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] front_value,
  output logic        is_empty,
  output logic [6:0]  stored_count
);
  import ious_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY,
    S_REPORT
  } state_t;

  state_t                state;
  kind_t                 op_kind;
  logic [VAL_BITS-1:0]   key;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  status_t               op_status;
  status_t               op_status_next;

  cell_ctl_t             ctl       [CAPACITY];
  logic [VAL_BITS-1:0]   cell_value[CAPACITY];
  logic                  cell_valid[CAPACITY];
  logic [CAPACITY-1:0]   match_vec;

  logic                  any_match;
  logic [IDX_W-1:0]      match_pos;
  logic                  do_push;
  logic                  do_pop;
  logic                  do_remove;

  assign in_ready = (state == S_IDLE);

  // Chain of cells: each takes its upper neighbor on a shift; the top one takes empty.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IDX_W-1:0] CI = IDX_W'(i);
    logic [VAL_BITS-1:0] up_value;
    logic                up_valid;

    if (i == CAPACITY - 1) begin : g_top
      assign up_value = '0;
      assign up_valid = 1'b0;
    end else begin : g_mid
      assign up_value = cell_value[i+1];
      assign up_valid = cell_valid[i+1];
    end

    // Cell control for this position.
    always_comb begin
      ctl[i].cmp   = (state == S_MATCH);
      ctl[i].shift = do_pop || (do_remove && (CI >= match_pos));
      ctl[i].load  = do_push && (count[IDX_W-1:0] == CI);
    end

    ious_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[i]),
      .key      (key),
      .up_value (up_value),
      .up_valid (up_valid),
      .value    (cell_value[i]),
      .valid    (cell_valid[i]),
      .match    (match_vec[i])
    );
  end

  // Values are unique, so at most one cell matches; an OR tree encodes its index.
  always_comb begin
    match_pos = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (match_vec[j]) begin
        match_pos = match_pos | IDX_W'(j);
      end
    end
  end
  assign any_match = |match_vec;

  // Decide the outcome of the held operation during the update step.
  always_comb begin
    do_push        = 1'b0;
    do_pop         = 1'b0;
    do_remove      = 1'b0;
    op_status_next = ST_OK;
    count_next     = count;
    if (state == S_APPLY) begin
      case (op_kind)
        KIND_PUSH: begin
          if (any_match) begin
            op_status_next = ST_DUP;
          end else if (count == CNT_W'(CAPACITY)) begin
            op_status_next = ST_FULL;
          end else begin
            do_push    = 1'b1;
            count_next = count + 1'b1;
          end
        end
        KIND_POP: begin
          if (count == '0) begin
            op_status_next = ST_EMPTY;
          end else begin
            do_pop     = 1'b1;
            count_next = count - 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (!any_match) begin
            op_status_next = ST_NOTFOUND;
          end else begin
            do_remove  = 1'b1;
            count_next = count - 1'b1;
          end
        end
        default: begin
          op_status_next = ST_OK;
        end
      endcase
    end
  end

  // Widened copies for fitting the fixed output field widths.
  logic [CNT_W+6:0]     count_wide;
  logic [VAL_BITS+31:0] front_wide;
  assign count_wide = {7'd0, count};
  assign front_wide = {32'd0, cell_value[0]};

  // Sequencer state, held operation and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result empties the register unless the report step refills it.
      if (out_valid && out_ready && (state != S_REPORT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind <= kind_t'(kind);
            key     <= item_value[VAL_BITS-1:0];
            state   <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          count     <= count_next;
          op_status <= op_status_next;
          state     <= S_REPORT;
        end
        S_REPORT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= op_status;
            is_empty     <= (count == '0);
            stored_count <= count_wide[6:0];
            front_value  <= (count == '0) ? 32'd0 : front_wide[31:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/insertion_ordered_unique_set_core_test.sv @@
// Self-checking testbench for the insertion-ordered unique set core.
`timescale 1ns / 100ps

module insertion_ordered_unique_set_core_test;
  import ious_pkg::*;

  // The input field is two bits wide, and its fourth code performs no operation.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int VALUE_POOL_SIZE = 96;

  // One result beat as the shadow set predicts it.
  typedef struct {
    status_t     st;
    logic [31:0] front;
    logic        empty;
    logic [6:0]  count;
  } set_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_PUSH;
  logic [31:0] item_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] front_value;
  logic        is_empty;
  logic [6:0]  stored_count;

  // Shadow copy of the stored values, oldest first, and the reports still owed.
  logic [31:0]  shadow_order[$];
  set_report_t  awaited_reports[$];
  logic [31:0]  value_pool[VALUE_POOL_SIZE];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned ops_sent[4];
  int unsigned status_seen[5];
  bit          gaps_enable = 1'b0;
  bit          stall_enable = 1'b0;
  int unsigned rx_hold_cycles = 0;

  insertion_ordered_unique_set_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .front_value  (front_value),
    .is_empty     (is_empty),
    .stored_count (stored_count)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Applies one operation to the shadow set and returns the report it causes.
  function automatic set_report_t apply_to_shadow_set(logic [1:0] op, logic [31:0] v);
    set_report_t r;
    int          pos;
    int          n;
    pos = -1;
    r.st = ST_OK;
    foreach (shadow_order[i]) begin
      if (pos < 0 && shadow_order[i] == v) pos = i;
    end
    case (op)
      KIND_PUSH: begin
        if (pos >= 0) r.st = ST_DUP;
        else if (shadow_order.size() >= CAPACITY) r.st = ST_FULL;
        else shadow_order.push_back(v);
      end
      KIND_POP: begin
        if (shadow_order.size() == 0) r.st = ST_EMPTY;
        else void'(shadow_order.pop_front());
      end
      KIND_REMOVE: begin
        if (pos < 0) r.st = ST_NOTFOUND;
        else shadow_order.delete(pos);
      end
      default: begin
        // The unused code leaves the set alone and reports it as it stands.
      end
    endcase
    n = shadow_order.size();
    r.front = (n != 0) ? shadow_order[0] : 32'd0;
    r.empty = (n == 0);
    r.count = 7'(n);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Offers one operation and holds it until the block takes the beat; called at a rising edge.
  task automatic send_op(logic [1:0] op, logic [31:0] v);
    in_valid   <= 1'b1;
    kind       <= op;
    item_value <= v;
    do @(posedge clk); while (!in_ready);
    awaited_reports.push_back(apply_to_shadow_set(op, v));
    ops_sent[op]++;
    if (gaps_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, plus a long hold when a test asks for one.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat against the oldest awaited report.
  always @(posedge clk) begin
    set_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("result beat arrived with no operation outstanding");
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", status, want.st);
        check_field("front_value", front_value, want.front);
        check_field("is_empty", is_empty, want.empty);
        check_field("stored_count", stored_count, want.count);
        status_seen[want.st]++;
      end
      results_seen++;
    end
  end

  // Picks a value from a small pool so that duplicates and hits are common.
  function automatic logic [31:0] pool_value();
    return value_pool[$urandom_range(0, VALUE_POOL_SIZE - 1)];
  endfunction

  // Empty-set cases, the extremes of the value, duplicates, middle and tail removal.
  task automatic test_directed_cases();
    send_op(KIND_POP, 32'h0000_0000);
    send_op(KIND_REMOVE, 32'h0000_0000);
    send_op(KIND_UNUSED, 32'hFFFF_FFFF);
    send_op(KIND_PUSH, 32'h0000_0000);
    send_op(KIND_PUSH, 32'hFFFF_FFFF);
    send_op(KIND_PUSH, 32'h0000_0000);
    send_op(KIND_PUSH, 32'h8000_0000);
    send_op(KIND_PUSH, 32'h0000_0001);
    send_op(KIND_PUSH, 32'h7FFF_FFFF);
    send_op(KIND_UNUSED, 32'h0000_0000);
    send_op(KIND_REMOVE, 32'hFFFF_FFFF);
    send_op(KIND_REMOVE, 32'h1234_5678);
    send_op(KIND_REMOVE, 32'h7FFF_FFFF);
    send_op(KIND_POP, 32'hFFFF_FFFF);
    send_op(KIND_PUSH, 32'h0000_0000);
    send_op(KIND_POP, 32'h0000_0000);
    send_op(KIND_POP, 32'h0000_0000);
    send_op(KIND_POP, 32'h0000_0000);
    send_op(KIND_POP, 32'h0000_0000);
    send_op(KIND_REMOVE, 32'h0000_0000);
  endtask

  // Fill to capacity while the receiver holds off, so the block backs up its input.
  task automatic test_fill_under_backpressure();
    rx_hold_cycles = 400;
    for (int i = 0; i < CAPACITY + 4; i++) send_op(KIND_PUSH, $urandom());
    // A duplicate on a full set must report duplicate, not full.
    send_op(KIND_PUSH, shadow_order[CAPACITY / 2]);
    send_op(KIND_REMOVE, shadow_order[CAPACITY / 2]);
    send_op(KIND_REMOVE, shadow_order[shadow_order.size() - 1]);
    send_op(KIND_PUSH, 32'hFFFF_FFFF);
    send_op(KIND_PUSH, 32'h0000_0000);
    send_op(KIND_PUSH, 32'h0000_0001);
  endtask

  // One random operation, weighted toward pushes by push_pct.
  task automatic send_random_op(int unsigned push_pct);
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      v = ($urandom_range(0, 9) == 0) ? $urandom() : pool_value();
      send_op(KIND_PUSH, v);
    end else if (r >= 98) begin
      send_op(KIND_UNUSED, $urandom());
    end else if (r % 2 == 0) begin
      send_op(KIND_POP, $urandom());
    end else begin
      if (shadow_order.size() != 0 && $urandom_range(0, 3) != 0)
        v = shadow_order[$urandom_range(0, shadow_order.size() - 1)];
      else
        v = ($urandom_range(0, 1) == 0) ? pool_value() : $urandom();
      send_op(KIND_REMOVE, v);
    end
  endtask

  // Segments with different push weights sweep the fill level between empty and full.
  task automatic test_random_mix();
    int unsigned push_pct;
    for (int seg = 0; seg < 32; seg++) begin
      case ($urandom_range(0, 3))
        0: push_pct = 20;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      gaps_enable  = ($urandom_range(0, 3) != 0);
      stall_enable = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 50; i++) send_random_op(push_pct);
    end
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_steady_stream();
    gaps_enable  = 1'b0;
    stall_enable = 1'b0;
    for (int i = 0; i < 150; i++) send_random_op((i < 75) ? 70 : 30);
  endtask

  initial begin : main
    foreach (value_pool[i]) value_pool[i] = $urandom();
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    gaps_enable  = 1'b1;
    stall_enable = 1'b1;
    test_fill_under_backpressure();
    test_random_mix();
    test_steady_stream();
    in_valid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (awaited_reports.size() != 0) report_mismatch("reports still awaited at end of run");

    $display("Ran %0d push, %0d pop, %0d remove and %0d no-op beats; %0d results checked.",
             ops_sent[KIND_PUSH], ops_sent[KIND_POP], ops_sent[KIND_REMOVE],
             ops_sent[KIND_UNUSED], results_seen);
    $display("Statuses seen: ok %0d, duplicate %0d, not found %0d, empty %0d, full %0d.",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
